/* rtl/core/ted_pkg.sv */
package ted_pkg;

  localparam int SMP_W           = 16;
  localparam int POS_W           = 12;
  localparam int POS_MAX         = (1 << POS_W) - 1;
  localparam int MAX_TRACE_LEN_D = 4096;
  localparam int BUF_DEPTH       = 4;
  localparam int BUF_AW          = $clog2(BUF_DEPTH);
  localparam int BUF_CW          = $clog2(BUF_DEPTH + 1);

  localparam logic KIND_MAX = 1'b0;
  localparam logic KIND_MIN = 1'b1;

  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_FLAT  = 2'd1;
  localparam logic [1:0] PH_TRACK = 2'd2;

  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic             last_sample;
  } ted_item_t;

  typedef struct packed {
    logic             extremum_kind;
    logic [POS_W-1:0] position;
    logic             last_event;
  } ted_res_t;

  typedef struct packed {
    logic [1:0] n;
    ted_res_t   r0;
    ted_res_t   r1;
  } ted_push_t;

endpackage

/* rtl/core/ted_chan_if.sv */
interface ted_in_if;
  import ted_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;
  logic                    last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface ted_out_if;
  import ted_pkg::*;

  logic             valid;
  logic             ready;
  logic             extremum_kind;
  logic [POS_W-1:0] position;
  logic             last_event;

  modport source (output valid, output extremum_kind, output position, output last_event,
                  input ready);
  modport sink (input valid, input extremum_kind, input position, input last_event,
                output ready);
endinterface

/* rtl/core/ted_core.sv */
module ted_core
  import ted_pkg::*;
#(
  parameter int MAX_TRACE_LEN = MAX_TRACE_LEN_D
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  ted_item_t item,
  output ted_push_t push
);

  localparam int         CAP_I   = (MAX_TRACE_LEN - 1 < POS_MAX) ? MAX_TRACE_LEN - 1 : POS_MAX;
  localparam logic [POS_W-1:0] POS_CAP = POS_W'(CAP_I);

  logic [SMP_W-1:0] prev_r, prev_nxt;
  logic [POS_W-1:0] idx_r, idx_nxt;
  logic             slope_r, slope_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [POS_W-1:0] pbeg_r, pbeg_nxt;
  logic [POS_W-1:0] peak_r, peak_nxt;

  logic signed [SMP_W-1:0] s_cur, s_prev;
  logic             gt, lt;
  logic [POS_W-1:0] idx_inc, beg, mid;

  assign s_cur   = $signed(item.sample);
  assign s_prev  = $signed(prev_r);
  assign gt      = s_cur > s_prev;
  assign lt      = s_cur < s_prev;
  assign idx_inc = (idx_r < POS_CAP) ? idx_r + POS_W'(1) : POS_CAP;
  assign beg     = (pbeg_r <= idx_r) ? pbeg_r : idx_r;
  assign mid     = idx_r - ((idx_r - beg) >> 1);

  always_comb begin
    prev_nxt  = item.sample;
    idx_nxt   = idx_inc;
    slope_nxt = slope_r;
    phase_nxt = phase_r;
    pbeg_nxt  = pbeg_r;
    peak_nxt  = peak_r;
    push      = '0;
    unique case (phase_r)
      PH_FLAT: begin
        if ((gt || lt) && !item.last_sample) begin
          slope_nxt = lt;
          pbeg_nxt  = idx_inc;
          peak_nxt  = '0;
          phase_nxt = PH_TRACK;
        end
      end
      PH_TRACK: begin
        if (gt || lt) begin
          if (lt != slope_r) begin
            if (slope_r) begin
              push.n  = 2'd2;
              push.r0 = '{extremum_kind: KIND_MAX, position: peak_r, last_event: 1'b0};
              push.r1 = '{extremum_kind: KIND_MIN, position: mid, last_event: 1'b1};
              slope_nxt = 1'b0;
            end else begin
              peak_nxt  = mid;
              slope_nxt = 1'b1;
            end
          end
          pbeg_nxt = idx_inc;
        end
        if (item.last_sample && slope_nxt) begin
          push.n  = 2'd1;
          push.r0 = '{extremum_kind: KIND_MAX, position: peak_nxt, last_event: 1'b1};
        end
      end
      default: begin
        idx_nxt   = '0;
        phase_nxt = PH_FLAT;
      end
    endcase
    if (item.last_sample) begin
      phase_nxt = PH_FIRST;
    end
    if (!adv) begin
      push.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      idx_r   <= '0;
      slope_r <= 1'b0;
      phase_r <= PH_FIRST;
      pbeg_r  <= '0;
      peak_r  <= '0;
    end else if (adv) begin
      prev_r  <= prev_nxt;
      idx_r   <= idx_nxt;
      slope_r <= slope_nxt;
      phase_r <= phase_nxt;
      pbeg_r  <= pbeg_nxt;
      peak_r  <= peak_nxt;
    end
  end

endmodule

/* rtl/core/ted_rbuf.sv */
module ted_rbuf
  import ted_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ted_push_t         push,
  input  logic              pop,
  output logic              room,
  output logic              rvalid,
  output ted_res_t          rdata,
  output logic [BUF_CW-1:0] fill
);

  ted_res_t          mem_r [BUF_DEPTH];
  logic [BUF_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [BUF_CW-1:0] cnt_r, cnt_nxt;
  logic              pop_ok;

  assign pop_ok  = pop && (cnt_r != '0);
  assign room    = cnt_r <= BUF_CW'(BUF_DEPTH - 2);
  assign rvalid  = cnt_r != '0;
  assign rdata   = mem_r[rd_r];
  assign fill    = cnt_r;
  assign wr_nxt  = wr_r + BUF_AW'(push.n);
  assign rd_nxt  = rd_r + BUF_AW'(pop_ok);
  assign cnt_nxt = cnt_r + BUF_CW'(push.n) - BUF_CW'(pop_ok);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_r + BUF_AW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/trace_extremum_detector.sv */
// Path: a request is held in the input register until the result buffer has
//   room for its results; they are then written into the result buffer and
//   show on out_res from there.
// Throughput: one sample per cycle while the buffer has two free entries; a trough
//   turn yields two results, drained one per cycle while out_res.ready is high, from a four-entry result buffer.
// Reset: synchronous, active low; clears trace state, input and buffer control.
module trace_extremum_detector
  import ted_pkg::*;
#(
  parameter int MAX_TRACE_LEN = MAX_TRACE_LEN_D
) (
  input  logic      clk,
  input  logic      rst_n,
  ted_in_if.sink    in_req,
  ted_out_if.source out_res
);

  logic              in_vld_r;
  ted_item_t         in_data_r;
  logic              room, go;
  ted_push_t         push;
  ted_res_t          rdata;
  logic [BUF_CW-1:0] fill;

  assign go           = in_vld_r && room;
  assign in_req.ready = !in_vld_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_req.ready) begin
      in_vld_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.ready && in_req.valid) begin
      in_data_r <= '{sample: in_req.sample, last_sample: in_req.last_sample};
    end
  end

  ted_core #(
    .MAX_TRACE_LEN(MAX_TRACE_LEN)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .adv  (go),
    .item (in_data_r),
    .push (push)
  );

  ted_rbuf u_rbuf (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_res.ready),
    .room  (room),
    .rvalid(out_res.valid),
    .rdata (rdata),
    .fill  (fill)
  );

  assign out_res.extremum_kind = rdata.extremum_kind;
  assign out_res.position      = rdata.position;
  assign out_res.last_event    = rdata.last_event;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= BUF_CW'(BUF_DEPTH))
    else $error("result buffer fill exceeds depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> (fill <= BUF_CW'(BUF_DEPTH - 2)))
    else $error("results pushed without room");

  a_hold_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !go) |=> (in_vld_r && $stable(in_data_r)))
    else $error("stalled request lost");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (push.r0.extremum_kind == KIND_MAX && push.r1.last_event))
    else $error("trough pair malformed");
`endif

endmodule

/* tb/trace_extremum_detector_tb.sv */
module trace_extremum_detector_tb;
  import ted_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [POS_W-1:0] POS_CAP = (MAX_TRACE_LEN_D - 1 < POS_MAX) ?
                                         POS_W'(MAX_TRACE_LEN_D - 1) : POS_W'(POS_MAX);
  localparam int WD_LIMIT    = 2000;
  localparam int RAND_ITEMS  = 1600;
  localparam int N_DIR       = 27;

  typedef struct {
    logic signed [SMP_W-1:0] smp;
    logic                    lst;
    bit                      fixed;
    int                      n;
    ted_res_t                r0;
    ted_res_t                r1;
  } dir_row_t;

  dir_row_t dir_tab [N_DIR] = '{
    '{16'sd100, 1'b1, 1'b1, 0, '0, '0},
    '{16'sd5, 1'b0, 1'b1, 0, '0, '0},
    '{16'sd5, 1'b1, 1'b1, 0, '0, '0},
    '{16'sd0, 1'b0, 1'b1, 0, '0, '0},
    '{16'sd7, 1'b1, 1'b1, 0, '0, '0},
    '{16'sh8000, 1'b0, 1'b1, 0, '0, '0},
    '{16'sh7FFF, 1'b0, 1'b1, 0, '0, '0},
    '{16'sh8000, 1'b0, 1'b1, 0, '0, '0},
    '{16'sh7FFF, 1'b1, 1'b1, 2, '{KIND_MAX, 12'd1, 1'b0}, '{KIND_MIN, 12'd2, 1'b1}},
    '{16'sd0, 1'b0, 1'b0, 0, '0, '0},
    '{16'sd1, 1'b0, 1'b0, 0, '0, '0},
    '{16'sd1, 1'b0, 1'b0, 0, '0, '0},
    '{16'sd1, 1'b0, 1'b0, 0, '0, '0},
    '{16'sd0, 1'b0, 1'b0, 0, '0, '0},
    '{16'sd0, 1'b0, 1'b0, 0, '0, '0},
    '{16'sd2, 1'b1, 1'b0, 0, '0, '0},
    '{16'sd0, 1'b0, 1'b1, 0, '0, '0},
    '{16'sd3, 1'b0, 1'b1, 0, '0, '0},
    '{16'sd1, 1'b1, 1'b1, 1, '{KIND_MAX, 12'd1, 1'b1}, '0},
    '{16'sd10, 1'b0, 1'b0, 0, '0, '0},
    '{16'sd5, 1'b0, 1'b0, 0, '0, '0},
    '{16'sd8, 1'b0, 1'b0, 0, '0, '0},
    '{16'sd8, 1'b1, 1'b0, 0, '0, '0},
    '{16'sd0, 1'b0, 1'b0, 0, '0, '0},
    '{16'sd1, 1'b0, 1'b0, 0, '0, '0},
    '{16'sd1, 1'b0, 1'b0, 0, '0, '0},
    '{16'sd2, 1'b1, 1'b0, 0, '0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  ted_in_if  in_req();
  ted_out_if out_res();

  trace_extremum_detector u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  logic signed [SMP_W-1:0] prev_smp;
  logic [POS_W-1:0]        idx_cur;
  logic                    slope_dn;
  logic [1:0]              scan_ph;
  logic [POS_W-1:0]        plat_beg;
  logic [POS_W-1:0]        peak_pos;
  ted_res_t                turn_res [2];

  ted_res_t extrema_q [$];
  int       err_cnt;
  int       idle_cnt;
  int       stall_left;
  int       stall_draw;
  bit       burst_mode;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int predict_extrema(input logic signed [SMP_W-1:0] s, input logic lst);
    int               n;
    logic [POS_W-1:0] nxt;
    logic [POS_W-1:0] e;
    logic [POS_W-1:0] b;
    logic [POS_W-1:0] mid;
    logic             up;
    logic             dn;
    n = 0;
    if (scan_ph != PH_FLAT && scan_ph != PH_TRACK) begin
      prev_smp = s;
      idx_cur  = '0;
      scan_ph  = lst ? PH_FIRST : PH_FLAT;
      return 0;
    end
    nxt = (idx_cur < POS_CAP) ? idx_cur + 1'b1 : POS_CAP;
    up  = s > prev_smp;
    dn  = s < prev_smp;
    if (scan_ph == PH_FLAT) begin
      if ((up || dn) && !lst) begin
        slope_dn = dn;
        plat_beg = nxt;
        peak_pos = '0;
        scan_ph  = PH_TRACK;
      end
    end else begin
      if (up || dn) begin
        if (dn != slope_dn) begin
          e   = idx_cur;
          b   = (plat_beg <= e) ? plat_beg : e;
          mid = e - ((e - b) >> 1);
          if (slope_dn) begin
            turn_res[n] = '{KIND_MAX, peak_pos, 1'b0};
            n++;
            turn_res[n] = '{KIND_MIN, mid, 1'b0};
            n++;
            slope_dn = 1'b0;
          end else begin
            peak_pos = mid;
            slope_dn = 1'b1;
          end
        end
        plat_beg = nxt;
      end
      if (lst && slope_dn) begin
        turn_res[n] = '{KIND_MAX, peak_pos, 1'b0};
        n++;
      end
    end
    prev_smp = s;
    idx_cur  = nxt;
    if (lst) scan_ph = PH_FIRST;
    if (n > 0) turn_res[n-1].last_event = 1'b1;
    return n;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    err_cnt++;
  endtask

  task automatic push_sample(input logic signed [SMP_W-1:0] smp, input logic lst,
                             input bit fixed, input int n_fix,
                             input ted_res_t f0, input ted_res_t f1);
    int gap;
    int n;
    gap = burst_mode ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid       <= 1'b1;
    in_req.sample      <= smp;
    in_req.last_sample <= lst;
    do @(posedge clk); while (!in_req.ready);
    n = predict_extrema(smp, lst);
    if (fixed) begin
      if (n_fix > 0) extrema_q.push_back(f0);
      if (n_fix > 1) extrema_q.push_back(f1);
    end else begin
      for (int i = 0; i < n; i++) extrema_q.push_back(turn_res[i]);
    end
  endtask

  task automatic drain_results();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (extrema_q.size() != 0);
  endtask

  task automatic check_result();
    ted_res_t want;
    if (extrema_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected result kind=%0b pos=%0d last=%0b",
                              out_res.extremum_kind, out_res.position, out_res.last_event));
      return;
    end
    want = extrema_q.pop_front();
    if (out_res.extremum_kind !== want.extremum_kind)
      flag_mismatch($sformatf("extremum_kind got %0b want %0b",
                              out_res.extremum_kind, want.extremum_kind));
    if (out_res.position !== want.position)
      flag_mismatch($sformatf("position got %0d want %0d", out_res.position, want.position));
    if (out_res.last_event !== want.last_event)
      flag_mismatch($sformatf("last_event got %0b want %0b",
                              out_res.last_event, want.last_event));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready) check_result();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      stall_left    <= 0;
    end else if (out_res.valid && out_res.ready) begin
      stall_draw = burst_mode ? 0 : $urandom_range(0, 11);
      if (stall_draw == 0) begin
        out_res.ready <= 1'b1;
      end else begin
        out_res.ready <= 1'b0;
        stall_left    <= stall_draw;
      end
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_res.ready <= 1'b1;
    end else begin
      out_res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WD_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    int                      sent;
    int                      len;
    int                      mode;
    logic signed [SMP_W-1:0] base;
    logic signed [SMP_W-1:0] s;
    rst_n              = 1'b0;
    in_req.valid       = 1'b0;
    in_req.sample      = '0;
    in_req.last_sample = 1'b0;
    burst_mode         = 1'b0;
    prev_smp           = '0;
    idx_cur            = '0;
    slope_dn           = 1'b0;
    scan_ph            = PH_FIRST;
    plat_beg           = '0;
    peak_pos           = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      push_sample(dir_tab[i].smp, dir_tab[i].lst, dir_tab[i].fixed, dir_tab[i].n,
                  dir_tab[i].r0, dir_tab[i].r1);
    drain_results();

    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (sent >= RAND_ITEMS / 2 && sent < RAND_ITEMS / 2 + 40) begin
        burst_mode = 1'b0;
        drain_results();
      end
      burst_mode = ($urandom_range(0, 3) == 0);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 24);
      mode = $urandom_range(0, 3);
      base = SMP_W'($urandom);
      for (int k = 0; k < len; k++) begin
        case (mode)
          0: s = base + SMP_W'($urandom_range(0, 2));
          1: s = SMP_W'($urandom);
          2: begin
            case ($urandom_range(0, 3))
              0: s = 16'sh8000;
              1: s = 16'sh7FFF;
              2: s = 16'sh0000;
              default: s = 16'shFFFF;
            endcase
          end
          default: begin
            base = base + SMP_W'($urandom_range(0, 4)) - SMP_W'(2);
            s    = base;
          end
        endcase
        push_sample(s, k == len - 1, 1'b0, 0, '0, '0);
        sent++;
      end
    end

    burst_mode = 1'b0;
    in_req.valid <= 1'b0;
    while (extrema_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ted_pkg.sv
rtl/core/ted_chan_if.sv
rtl/core/ted_core.sv
rtl/core/ted_rbuf.sv
rtl/core/trace_extremum_detector.sv
tb/trace_extremum_detector_tb.sv
